// ===== rtl/csfu_pkg.sv =====
// ----------------------------------------------------------------------------
// csfu_pkg
// Shared types and constants of the cubic surface fit upscaler: the ten 5x5
// fit masks, their denominator scales and the divider handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package csfu_pkg;

  localparam int NumMasks  = 10;
  localparam int WinTaps   = 25;
  localparam int CommonDen = 2100;
  localparam int SatLimit  = 256 * 2100;

  typedef logic signed [19:0] sum_t;
  typedef logic signed [25:0] scaled_t;

  typedef enum logic [1:0] {
    CfgCoordStep = 2'd0,
    CfgSrcWidth  = 2'd1,
    CfgSrcHeight = 2'd2
  } cfg_idx_e;

  // Taps in raster order: mask row 0 sits at window offset +2 in y.
  localparam logic signed [7:0] FitMask [NumMasks][WinTaps] = '{
    '{-8'sd13, 8'sd2, 8'sd7, 8'sd2, -8'sd13, 8'sd2, 8'sd17, 8'sd22, 8'sd17, 8'sd2,
      8'sd7, 8'sd22, 8'sd27, 8'sd22, 8'sd7, 8'sd2, 8'sd17, 8'sd22, 8'sd17, 8'sd2,
      -8'sd13, 8'sd2, 8'sd7, 8'sd2, -8'sd13},
    '{8'sd31, -8'sd44, 8'sd0, 8'sd44, -8'sd31, -8'sd5, -8'sd62, 8'sd0, 8'sd62, 8'sd5,
      -8'sd17, -8'sd68, 8'sd0, 8'sd68, 8'sd17, -8'sd5, -8'sd62, 8'sd0, 8'sd62, 8'sd5,
      8'sd31, -8'sd44, 8'sd0, 8'sd44, -8'sd31},
    '{-8'sd31, 8'sd5, 8'sd17, 8'sd5, -8'sd31, 8'sd44, 8'sd62, 8'sd68, 8'sd62, 8'sd44,
      8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd44, -8'sd62, -8'sd68, -8'sd62, -8'sd44,
      8'sd31, -8'sd5, -8'sd17, -8'sd5, 8'sd31},
    '{8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2, 8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2,
      8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2, 8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2,
      8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2},
    '{-8'sd4, -8'sd2, 8'sd0, 8'sd2, 8'sd4, -8'sd2, -8'sd1, 8'sd0, 8'sd1, 8'sd2,
      8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd2, 8'sd1, 8'sd0, -8'sd1, -8'sd2,
      8'sd4, 8'sd2, 8'sd0, -8'sd2, -8'sd4},
    '{8'sd2, 8'sd2, 8'sd2, 8'sd2, 8'sd2, -8'sd1, -8'sd1, -8'sd1, -8'sd1, -8'sd1,
      -8'sd2, -8'sd2, -8'sd2, -8'sd2, -8'sd2, -8'sd1, -8'sd1, -8'sd1, -8'sd1, -8'sd1,
      8'sd2, 8'sd2, 8'sd2, 8'sd2, 8'sd2},
    '{-8'sd1, 8'sd2, 8'sd0, -8'sd2, 8'sd1, -8'sd1, 8'sd2, 8'sd0, -8'sd2, 8'sd1,
      -8'sd1, 8'sd2, 8'sd0, -8'sd2, 8'sd1, -8'sd1, 8'sd2, 8'sd0, -8'sd2, 8'sd1,
      -8'sd1, 8'sd2, 8'sd0, -8'sd2, 8'sd1},
    '{8'sd4, -8'sd2, -8'sd4, -8'sd2, 8'sd4, 8'sd2, -8'sd1, -8'sd2, -8'sd1, 8'sd2,
      8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd2, 8'sd1, 8'sd2, 8'sd1, -8'sd2,
      -8'sd4, 8'sd2, 8'sd4, 8'sd2, -8'sd4},
    '{-8'sd4, -8'sd2, 8'sd0, 8'sd2, 8'sd4, 8'sd2, 8'sd1, 8'sd0, -8'sd1, -8'sd2,
      8'sd4, 8'sd2, 8'sd0, -8'sd2, -8'sd4, 8'sd2, 8'sd1, 8'sd0, -8'sd1, -8'sd2,
      -8'sd4, -8'sd2, 8'sd0, 8'sd2, 8'sd4},
    '{8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1, -8'sd2, -8'sd2, -8'sd2, -8'sd2, -8'sd2,
      8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd2, 8'sd2, 8'sd2, 8'sd2, 8'sd2,
      -8'sd1, -8'sd1, -8'sd1, -8'sd1, -8'sd1}
  };

  // 2100 / denominator of each mask
  localparam logic [5:0] DenScale [NumMasks] = '{
    6'd12, 6'd5, 6'd5, 6'd30, 6'd21, 6'd30, 6'd35, 6'd15, 6'd15, 6'd35
  };

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [27:0] mag;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] pixel;
    logic       clipped;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/csfu_div.sv =====
// ----------------------------------------------------------------------------
// csfu_div
// Divides the surface value (already scaled down by 2^32) by the common
// denominator through a reciprocal multiply and saturates it to 0..255.
// The result word is registered and shows in the cycle after the request.
// ----------------------------------------------------------------------------
`default_nettype none

module csfu_div
  import csfu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t div_req_i,
  output div_rsp_t      div_rsp_o
);

  // ceil(2^32 / 2100); exact for every dividend below 256 * 2100
  localparam logic [20:0] RecipDen = 21'd2045223;

  div_rsp_t    rsp_q;
  div_rsp_t    rsp_d;
  logic [39:0] prod;

  always_comb begin
    prod  = 40'(div_req_i.mag[19:0]) * 40'(RecipDen);
    rsp_d = '0;
    if (div_req_i.start) begin
      if (div_req_i.neg) begin
        rsp_d = '{done: 1'b1, pixel: 8'd0, clipped: div_req_i.mag >= 28'(CommonDen)};
      end else if (div_req_i.mag >= 28'(SatLimit)) begin
        rsp_d = '{done: 1'b1, pixel: 8'hFF, clipped: 1'b1};
      end else begin
        rsp_d = '{done: 1'b1, pixel: prod[39:32], clipped: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= rsp_d;
    end
  end

  assign div_rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/cubic_surface_fit_upscaler_top.sv =====
// ----------------------------------------------------------------------------
// cubic_surface_fit_upscaler_top
// Resamples an 8-bit image by evaluating a least-squares cubic surface
// fitted over the 5x5 window around each mapped source position.
// ----------------------------------------------------------------------------
// A load word (op 0) writes one source pixel in the cycle it is taken and
// leaves busy_o low. An interpolate word (op 1) holds busy_o high while it
// maps the coordinate, forms the dx/dy monomials, reads the window through
// the image memory read port (one pixel a cycle, registered read data),
// scales the ten mask sums, weights them through one multiplier, and does
// the reciprocal divide and saturation. The result is shown on pixel_out_o
// and clipped_o for exactly one cycle with done_o, in the first cycle that
// busy_o is low again, so the next word can be taken at the end of that
// cycle. The result cannot be held off, so capture it then. Coordinates
// beyond the output raise no done_o.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_surface_fit_upscaler_top
  import csfu_pkg::*;
#(
  parameter int SRC_DIM = 256,
  parameter int OUT_DIM = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic        op_i,
  input  wire logic [9:0]  col_i,
  input  wire logic [9:0]  row_i,
  input  wire logic [7:0]  pixel_in_i,
  output      logic        done_o,
  output      logic [7:0]  pixel_out_o,
  output      logic        clipped_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  localparam int CW    = $clog2(SRC_DIM);
  localparam int Depth = SRC_DIM * SRC_DIM;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle, StMap, StMono1, StMono2, StRead, StScale, StMac, StWait
  } state_e;

  state_e st_q;

  logic [16:0] step_q;
  logic [8:0]  width_q, height_q;

  logic [7:0]  mem [Depth];
  logic [7:0]  rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [9:0]  col_q, row_q;
  logic [10:0] bx_q, by_q;
  logic [15:0] dx_q, dy_q;
  logic [11:0] lim_w_q, lim_h_q;
  logic [31:0] xx_q, xy_q, yy_q, xxx_q, xxy_q, xyy_q, yyy_q;

  logic [2:0]  r_q, c_q;
  logic [4:0]  k_q, pend_k_q;
  logic        pend_q;
  sum_t        s_q [NumMasks];
  sum_t        s_d [NumMasks];
  scaled_t     sc_q [NumMasks];
  logic [3:0]  idx_q;
  logic signed [63:0] prod_q, acc_q;
  logic        prod_v_q;
  logic [31:0] mono_sel;

  logic        accept;
  logic        done_q;
  logic [7:0]  pix_q;
  logic        clip_q;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [63:0] acc_mag;
  logic [26:0] posx, posy;
  logic [CW-1:0] xc, yc;

  function automatic logic [11:0] size_lim(input logic [8:0] reg_v);
    logic [11:0] v;
    v = 12'(reg_v);
    if (v == 12'd0) v = 12'd1;
    if (v > 12'(SRC_DIM)) v = 12'(SRC_DIM);
    return v;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic signed [11:0] v,
                                          input logic [11:0] lim);
    logic [11:0] top;
    top = lim - 12'd1;
    if (v < 0) return '0;
    if ($unsigned(v) > top) return top[CW-1:0];
    return v[CW-1:0];
  endfunction

  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != StIdle);

  assign posx = 27'(col_q) * 27'(step_q);
  assign posy = 27'(row_q) * 27'(step_q);

  assign xc = clamp($signed(12'(bx_q) + 12'(c_q) - 12'd2), lim_w_q);
  assign yc = clamp($signed(12'(by_q) + 12'd2 - 12'(r_q)), lim_h_q);
  assign rd_addr = AW'(32'(yc) * SRC_DIM + 32'(xc));

  assign wr_en   = accept && !op_i && (32'(col_i) < SRC_DIM) && (32'(row_i) < SRC_DIM);
  assign wr_addr = AW'(32'(row_i) * SRC_DIM + 32'(col_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= pixel_in_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    for (int i = 0; i < NumMasks; i++) begin
      s_d[i] = s_q[i] + 20'($signed({1'b0, rd_data_q})) * 20'(FitMask[i][pend_k_q]);
    end
  end

  always_comb begin
    case (idx_q)
      4'd1:    mono_sel = {dx_q, 16'd0};
      4'd2:    mono_sel = {dy_q, 16'd0};
      4'd3:    mono_sel = xx_q;
      4'd4:    mono_sel = xy_q;
      4'd5:    mono_sel = yy_q;
      4'd6:    mono_sel = xxx_q;
      4'd7:    mono_sel = xxy_q;
      4'd8:    mono_sel = xyy_q;
      4'd9:    mono_sel = yyy_q;
      default: mono_sel = '0;
    endcase
  end

  assign acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);

  always_comb begin
    div_req.start = (st_q == StMac) && (idx_q == 4'(NumMasks)) && !prod_v_q;
    div_req.neg   = acc_q[63];
    div_req.mag   = acc_mag[59:32];
  end

  csfu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      step_q   <= 17'd32768;
      width_q  <= 9'd256;
      height_q <= 9'd256;
      col_q    <= '0;
      row_q    <= '0;
      bx_q     <= '0;
      by_q     <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      lim_w_q  <= '0;
      lim_h_q  <= '0;
      xx_q     <= '0;
      xy_q     <= '0;
      yy_q     <= '0;
      xxx_q    <= '0;
      xxy_q    <= '0;
      xyy_q    <= '0;
      yyy_q    <= '0;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      pend_k_q <= '0;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      prod_q   <= '0;
      prod_v_q <= 1'b0;
      acc_q    <= '0;
      done_q   <= 1'b0;
      pix_q    <= '0;
      clip_q   <= 1'b0;
      for (int i = 0; i < NumMasks; i++) begin
        s_q[i]  <= '0;
        sc_q[i] <= '0;
      end
    end else begin
      done_q <= (st_q == StWait) && div_rsp.done;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCoordStep: step_q   <= cfg_data_i;
          CfgSrcWidth:  width_q  <= cfg_data_i[8:0];
          CfgSrcHeight: height_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      case (st_q)
        StIdle: begin
          if (accept && op_i && (32'(col_i) < OUT_DIM) && (32'(row_i) < OUT_DIM)) begin
            col_q <= col_i;
            row_q <= row_i;
            st_q  <= StMap;
          end
        end
        StMap: begin
          bx_q    <= posx[26:16];
          by_q    <= posy[26:16];
          dx_q    <= posx[15:0];
          dy_q    <= posy[15:0];
          lim_w_q <= size_lim(width_q);
          lim_h_q <= size_lim(height_q);
          for (int i = 0; i < NumMasks; i++) s_q[i] <= '0;
          st_q    <= StMono1;
        end
        StMono1: begin
          xx_q <= 32'(dx_q) * 32'(dx_q);
          xy_q <= 32'(dx_q) * 32'(dy_q);
          yy_q <= 32'(dy_q) * 32'(dy_q);
          st_q <= StMono2;
        end
        StMono2: begin
          xxx_q <= 32'((48'(xx_q) * 48'(dx_q)) >> 16);
          xxy_q <= 32'((48'(xx_q) * 48'(dy_q)) >> 16);
          xyy_q <= 32'((48'(xy_q) * 48'(dy_q)) >> 16);
          yyy_q <= 32'((48'(yy_q) * 48'(dy_q)) >> 16);
          r_q    <= '0;
          c_q    <= '0;
          k_q    <= '0;
          pend_q <= 1'b0;
          st_q   <= StRead;
        end
        StRead: begin
          // issue one window read a cycle, fold in the word from the last one
          pend_q <= (k_q < 5'(WinTaps));
          if (k_q < 5'(WinTaps)) begin
            pend_k_q <= k_q;
            k_q      <= k_q + 5'd1;
            if (c_q == 3'd4) begin
              c_q <= '0;
              r_q <= r_q + 3'd1;
            end else begin
              c_q <= c_q + 3'd1;
            end
          end
          if (pend_q) begin
            for (int i = 0; i < NumMasks; i++) s_q[i] <= s_d[i];
          end
          if (pend_q && (k_q == 5'(WinTaps))) begin
            st_q <= StScale;
          end
        end
        StScale: begin
          for (int i = 0; i < NumMasks; i++) begin
            sc_q[i] <= 26'(s_q[i]) * 26'($signed({1'b0, DenScale[i]}));
          end
          idx_q    <= '0;
          prod_v_q <= 1'b0;
          acc_q    <= '0;
          st_q     <= StMac;
        end
        StMac: begin
          if (idx_q < 4'(NumMasks)) begin
            if (idx_q == 4'd0) begin
              prod_q <= 64'(sc_q[idx_q]) <<< 32;
            end else begin
              prod_q <= 64'(sc_q[idx_q]) * 64'($signed({1'b0, mono_sel}));
            end
            idx_q <= idx_q + 4'd1;
          end
          prod_v_q <= (idx_q < 4'(NumMasks));
          if (prod_v_q) begin
            acc_q <= acc_q + prod_q;
          end
          if (div_req.start) begin
            st_q <= StWait;
          end
        end
        StWait: begin
          if (div_rsp.done) begin
            pix_q  <= div_rsp.pixel;
            clip_q <= div_rsp.clipped;
            st_q   <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign done_o      = done_q;
  assign pixel_out_o = pix_q;
  assign clipped_o   = clip_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result word shown while still busy");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !op_i) |=> (!busy_o && !done_o))
    else $error("load word started a computation");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == StWait))
    else $error("divider finished outside the wait state");

  a_sat_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |-> (pixel_out_o == 8'd0 || pixel_out_o == 8'hFF))
    else $error("clipped result not at a rail");

endmodule

`default_nettype wire
